/* src/mfoc_pkg.sv */
// Shared types, constants and flag/drive functions for the machine function output controller.
package mfoc_pkg;

	localparam int NUM_OUTPUTS  = 6;
	localparam int NUM_SECTIONS = 16;
	localparam int WATCHDOG_MS  = 2000;

	localparam int FUNC_COUNT  = 21;
	localparam int MAP_W       = 30;
	localparam int LEVEL_W     = 6;
	localparam int SECTION_W   = 16;
	localparam int WD_W        = 12;
	localparam int ELAPSED_W   = 18;
	localparam int MS_PER_S    = 1000;
	localparam int CFG_INDEX_W = 3;

	localparam logic [SECTION_W-1:0] SECTION_MASK =
		SECTION_W'((32'd1 << NUM_SECTIONS) - 32'd1);
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [WD_W-1:0] WD_MAX = '1;
	localparam logic [WD_W-1:0] WD_LIMIT = WD_W'(WATCHDOG_MS);
	localparam logic [29:0] MAP_RESET = 30'd206703681;

	// function flag bit positions
	localparam int FN_HYD_UP     = 16;
	localparam int FN_HYD_DOWN   = 17;
	localparam int FN_TRAM_RIGHT = 18;
	localparam int FN_TRAM_LEFT  = 19;
	localparam int FN_GEO_STOP   = 20;

	localparam logic [7:0] HYD_OFF  = 8'h00;
	localparam logic [7:0] HYD_DOWN = 8'h01;
	localparam logic [7:0] HYD_UP   = 8'h02;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_MESSAGE = 2'd1,
		OP_REFRESH = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_RAISE_SECONDS  = 3'd0,
		CFG_LOWER_SECONDS  = 3'd1,
		CFG_HYD_ENABLE     = 3'd2,
		CFG_PIN_ACTIVE_HI  = 3'd3,
		CFG_OUTPUT_MAP     = 3'd4,
		CFG_VALVE_MODE     = 3'd5,
		CFG_SECTION_ACTIVE = 3'd6
	} cfg_index_t;

	typedef struct packed {
		opcode_t               opcode;
		logic                  link_up;
		logic                  length_ok;
		logic [7:0]            hyd_command;
		logic [7:0]            tram_byte;
		logic [7:0]            geo_byte;
		logic [SECTION_W-1:0]  section_bits;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]    pin_levels;
		logic                  outputs_written;
		logic [FUNC_COUNT-1:0] function_flags;
		logic [7:0]            hyd_active;
		logic                  watchdog_tripped;
	} result_t;

	function automatic logic [FUNC_COUNT-1:0] form_flags(
		input logic [SECTION_W-1:0] sections,
		input logic [7:0]           running,
		input logic [1:0]           tram,
		input logic                 geo
	);
		logic [FUNC_COUNT-1:0] f;
		f = '0;
		f[SECTION_W-1:0] = sections & SECTION_MASK;
		f[FN_HYD_UP]     = (running == HYD_UP);
		f[FN_HYD_DOWN]   = (running == HYD_DOWN);
		f[FN_TRAM_RIGHT] = tram[0];
		f[FN_TRAM_LEFT]  = tram[1];
		f[FN_GEO_STOP]   = geo;
		return f;
	endfunction

	// Unassigned outputs and valve outputs keep their previous level.
	function automatic logic [LEVEL_W-1:0] drive_levels(
		input logic [LEVEL_W-1:0]    levels,
		input logic [FUNC_COUNT-1:0] flags,
		input logic [MAP_W-1:0]      fmap,
		input logic                  valve,
		input logic                  active_high
	);
		logic [LEVEL_W-1:0] lv;
		logic [4:0]         fn;
		logic               s;
		lv = levels;
		for (int n = 0; n < LEVEL_W; n++) begin
			fn = fmap[5*n +: 5];
			s  = 1'b0;
			if (fn != 5'd0 && fn <= 5'(FUNC_COUNT))
				s = flags[fn - 5'd1];
			if (n < NUM_OUTPUTS && !(valve && (n == 4 || n == 5))
					&& fn != 5'd0 && fn <= 5'(FUNC_COUNT))
				lv[n] = active_high ? ~s : s;
		end
		return lv;
	endfunction

endpackage

/* src/machine_function_output_controller_unit.sv */
// Top level of the machine function output controller: input register, core, result buffer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | to block  | in_valid / in_ready  | opcode link_up length_ok hyd_command
//          |           |                      | tram_byte geo_byte section_bits
//  out     | from block| out_valid / out_ready| pin_levels outputs_written function_flags
//          |           |                      | hyd_active watchdog_tripped
//  cfg     | to block  | cfg_wr_en            | cfg_index cfg_data
//
// One transaction per cycle unless out_ready stalls; input and result are each registered.
// Each item is resolved by combinational logic between the input register and the core state.
// The two-entry result buffer keeps input accepting while one result waits on out_ready.
// Reset (arst_n low) empties both stages and loads register and state reset values.
module machine_function_output_controller_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mfoc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mfoc_pkg::MAP_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       opcode,
	input  logic                             link_up,
	input  logic                             length_ok,
	input  logic [7:0]                       hyd_command,
	input  logic [7:0]                       tram_byte,
	input  logic [7:0]                       geo_byte,
	input  logic [mfoc_pkg::SECTION_W-1:0]   section_bits,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mfoc_pkg::LEVEL_W-1:0]     pin_levels,
	output logic                             outputs_written,
	output logic [mfoc_pkg::FUNC_COUNT-1:0]  function_flags,
	output logic [7:0]                       hyd_active,
	output logic                             watchdog_tripped
);
	import mfoc_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	logic    adv, buf_ready, in_fire;
	result_t core_result, out_result;

	assign adv      = valid_s1 && buf_ready;
	assign in_ready = !valid_s1 || buf_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.opcode       <= opcode_t'(opcode);
			item_s1.link_up      <= link_up;
			item_s1.length_ok    <= length_ok;
			item_s1.hyd_command  <= hyd_command;
			item_s1.tram_byte    <= tram_byte;
			item_s1.geo_byte     <= geo_byte;
			item_s1.section_bits <= section_bits;
		end
	end

	mfoc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.adv       (adv),
		.item      (item_s1),
		.result    (core_result)
	);

	mfoc_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (adv),
		.push_data  (core_result),
		.push_ready (buf_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_result)
	);

	assign pin_levels       = out_result.pin_levels;
	assign outputs_written  = out_result.outputs_written;
	assign function_flags   = out_result.function_flags;
	assign hyd_active       = out_result.hyd_active;
	assign watchdog_tripped = out_result.watchdog_tripped;

endmodule

/* src/mfoc_core.sv */
// Configuration registers, controller state and the single-pass next-state logic.
module mfoc_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mfoc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mfoc_pkg::MAP_W-1:0]    cfg_data,
	input  logic                          adv,
	input  mfoc_pkg::item_t               item,
	output mfoc_pkg::result_t             result
);
	import mfoc_pkg::*;

	logic [7:0]            raise_q, lower_q;
	logic                  hyd_en_q, active_high_q, valve_q, sect_active_q;
	logic [MAP_W-1:0]      fmap_q;

	logic                  link_was_up_q, armed_q;
	logic [WD_W-1:0]       wd_ms_q;
	logic [7:0]            running_q, last_cmd_q;
	logic                  timing_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [SECTION_W-1:0]  section_q;
	logic [1:0]            tram_q;
	logic                  geo_q;
	logic [FUNC_COUNT-1:0] func_q;
	logic [LEVEL_W-1:0]    level_q;

	logic                  link_was_up_d, armed_d;
	logic [WD_W-1:0]       wd_ms_d;
	logic [7:0]            running_d, last_cmd_d;
	logic                  timing_d;
	logic [ELAPSED_W-1:0]  elapsed_d;
	logic [SECTION_W-1:0]  section_d;
	logic [1:0]            tram_d;
	logic                  geo_d;
	logic [FUNC_COUNT-1:0] func_d;
	logic [LEVEL_W-1:0]    level_d;
	logic                  written_d, tripped_d;
	logic [7:0]            secs_max;
	logic [ELAPSED_W-1:0]  limit_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raise_q       <= '0;
			lower_q       <= '0;
			hyd_en_q      <= 1'b0;
			active_high_q <= 1'b1;
			fmap_q        <= MAP_RESET;
			valve_q       <= 1'b0;
			sect_active_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_RAISE_SECONDS:  raise_q       <= cfg_data[7:0];
				CFG_LOWER_SECONDS:  lower_q       <= cfg_data[7:0];
				CFG_HYD_ENABLE:     hyd_en_q      <= cfg_data[0];
				CFG_PIN_ACTIVE_HI:  active_high_q <= cfg_data[0];
				CFG_OUTPUT_MAP:     fmap_q        <= cfg_data;
				CFG_VALVE_MODE:     valve_q       <= cfg_data[0];
				CFG_SECTION_ACTIVE: sect_active_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		link_was_up_d = link_was_up_q;
		armed_d       = armed_q;
		wd_ms_d       = wd_ms_q;
		running_d     = running_q;
		last_cmd_d    = last_cmd_q;
		timing_d      = timing_q;
		elapsed_d     = elapsed_q;
		section_d     = section_q;
		tram_d        = tram_q;
		geo_d         = geo_q;
		func_d        = func_q;
		level_d       = level_q;
		written_d     = 1'b0;
		tripped_d     = 1'b0;
		secs_max      = (running_q == HYD_UP) ? raise_q : lower_q;
		limit_ms      = ELAPSED_W'(secs_max) * ELAPSED_W'(MS_PER_S);

		unique case (item.opcode)
			OP_TICK: begin
				// link fall or watchdog: clear everything, keep the last command
				if (link_was_up_q && !item.link_up) begin
					func_d    = '0;
					section_d = '0;
					running_d = HYD_OFF;
					timing_d  = 1'b0;
					elapsed_d = '0;
					tram_d    = '0;
					geo_d     = 1'b0;
					level_d   = drive_levels(level_q, '0, fmap_q, valve_q, active_high_q);
					armed_d   = 1'b0;
					wd_ms_d   = '0;
					written_d = 1'b1;
				end
				link_was_up_d = item.link_up;
				if (armed_d) begin
					if (wd_ms_d != WD_MAX)
						wd_ms_d = wd_ms_d + 1'b1;
					if (wd_ms_d > WD_LIMIT) begin
						func_d    = '0;
						section_d = '0;
						running_d = HYD_OFF;
						timing_d  = 1'b0;
						elapsed_d = '0;
						tram_d    = '0;
						geo_d     = 1'b0;
						level_d   = drive_levels(level_q, '0, fmap_q, valve_q, active_high_q);
						armed_d   = 1'b0;
						wd_ms_d   = '0;
						written_d = 1'b1;
						tripped_d = 1'b1;
					end
				end
				if (timing_d && elapsed_d != ELAPSED_MAX)
					elapsed_d = elapsed_d + 1'b1;
				// timing_d still set means no clear happened, so running_q is current
				if (hyd_en_q && running_d != HYD_OFF && timing_d && elapsed_d > limit_ms) begin
					running_d = HYD_OFF;
					timing_d  = 1'b0;
					elapsed_d = '0;
					func_d    = form_flags(section_d, HYD_OFF, tram_d, geo_d);
					level_d   = drive_levels(level_q, func_d, fmap_q, valve_q, active_high_q);
					written_d = 1'b1;
				end
			end
			OP_MESSAGE: begin
				if (item.length_ok) begin
					armed_d = 1'b1;
					wd_ms_d = '0;
					if (hyd_en_q && item.hyd_command != last_cmd_q) begin
						running_d  = item.hyd_command;
						timing_d   = (item.hyd_command != HYD_OFF);
						elapsed_d  = '0;
						last_cmd_d = item.hyd_command;
					end
					tram_d    = item.tram_byte[1:0];
					geo_d     = (item.geo_byte != 8'd0);
					section_d = sect_active_q ? (item.section_bits & SECTION_MASK) : '0;
					func_d    = form_flags(section_d, running_d, tram_d, geo_d);
					if (func_d != func_q) begin
						level_d   = drive_levels(level_q, func_d, fmap_q, valve_q,
							active_high_q);
						written_d = 1'b1;
					end
				end
			end
			OP_REFRESH: begin
				level_d   = drive_levels(level_q, func_q, fmap_q, valve_q, active_high_q);
				written_d = 1'b1;
			end
			OP_NONE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_was_up_q <= 1'b1;
			armed_q       <= 1'b0;
			wd_ms_q       <= '0;
			running_q     <= '0;
			last_cmd_q    <= '0;
			timing_q      <= 1'b0;
			elapsed_q     <= '0;
			section_q     <= '0;
			tram_q        <= '0;
			geo_q         <= 1'b0;
			func_q        <= '0;
			level_q       <= '0;
		end else if (adv) begin
			link_was_up_q <= link_was_up_d;
			armed_q       <= armed_d;
			wd_ms_q       <= wd_ms_d;
			running_q     <= running_d;
			last_cmd_q    <= last_cmd_d;
			timing_q      <= timing_d;
			elapsed_q     <= elapsed_d;
			section_q     <= section_d;
			tram_q        <= tram_d;
			geo_q         <= geo_d;
			func_q        <= func_d;
			level_q       <= level_d;
		end
	end

	assign result.pin_levels       = level_d;
	assign result.outputs_written  = written_d;
	assign result.function_flags   = func_d;
	assign result.hyd_active       = running_d;
	assign result.watchdog_tripped = tripped_d;

	a_trip_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tripped_d |=> func_q == '0 && !armed_q && running_q == HYD_OFF)
		else $error("watchdog trip did not clear the controller state");

	a_idle_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		!timing_q |-> elapsed_q == '0)
		else $error("hydraulic elapsed count nonzero while not timing");

	a_hyd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(func_q[FN_HYD_UP] && func_q[FN_HYD_DOWN]))
		else $error("hydraulic up and down flags both set");

	a_wd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wd_ms_q <= WD_LIMIT && (armed_q || wd_ms_q == '0))
		else $error("watchdog count out of range");

endmodule

/* src/mfoc_skid.sv */
// Two-entry result buffer: output register plus skid register.
module mfoc_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mfoc_pkg::result_t   push_data,
	output logic                push_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output mfoc_pkg::result_t   out_data
);
	import mfoc_pkg::*;

	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    pop;

	assign pop        = out_valid_q && out_ready;
	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload: refill output from skid first, else park a new transaction in skid
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

/* sim/machine_function_output_controller_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the machine function output controller top level.
module machine_function_output_controller_unit_tb;
	import mfoc_pkg::*;

	localparam int PHASES           = 6;
	localparam int EVENTS_PER_PHASE = 75;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	cfg_index_t            cfg_index = CFG_RAISE_SECONDS;
	logic [MAP_W-1:0]      cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	item_t                 drv_item  = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [LEVEL_W-1:0]    pin_levels;
	logic                  outputs_written;
	logic [FUNC_COUNT-1:0] function_flags;
	logic [7:0]            hyd_active;
	logic                  watchdog_tripped;

	// register mirror
	logic [7:0]       raise_s_reg   = 8'd0;
	logic [7:0]       lower_s_reg   = 8'd0;
	logic             hyd_en_reg    = 1'b0;
	logic             active_hi_reg = 1'b1;
	logic [MAP_W-1:0] fmap_reg      = MAP_RESET;
	logic             valve_reg     = 1'b0;
	logic             sect_on_reg   = 1'b1;

	// machine state mirror
	logic                  link_prev  = 1'b1;
	logic                  wd_armed   = 1'b0;
	logic [WD_W-1:0]       wd_count   = '0;
	logic [7:0]            hyd_run    = HYD_OFF;
	logic [7:0]            hyd_last   = HYD_OFF;
	logic                  hyd_timing = 1'b0;
	logic [ELAPSED_W-1:0]  hyd_ms     = '0;
	logic [SECTION_W-1:0]  sect_st    = '0;
	logic [1:0]            tram_st    = '0;
	logic                  geo_st     = 1'b0;
	logic [FUNC_COUNT-1:0] flags_st   = '0;
	logic [LEVEL_W-1:0]    levels_st  = '0;

	item_t   machine_items_q[$];
	result_t relay_results_q[$];

	int send_idle_pct  = 15;
	int recv_idle_pct  = 15;
	int bursts_left    = 0;
	int fail_count     = 0;
	int items_accepted = 0;
	int results_seen   = 0;
	int link_clears    = 0;
	int wd_clears      = 0;
	int hyd_stops      = 0;

	machine_function_output_controller_unit DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (drv_item.opcode),
		.link_up          (drv_item.link_up),
		.length_ok        (drv_item.length_ok),
		.hyd_command      (drv_item.hyd_command),
		.tram_byte        (drv_item.tram_byte),
		.geo_byte         (drv_item.geo_byte),
		.section_bits     (drv_item.section_bits),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.pin_levels       (pin_levels),
		.outputs_written  (outputs_written),
		.function_flags   (function_flags),
		.hyd_active       (hyd_active),
		.watchdog_tripped (watchdog_tripped)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [FUNC_COUNT-1:0] machine_flags();
		logic [FUNC_COUNT-1:0] f;
		f = '0;
		f[SECTION_W-1:0] = sect_st & SECTION_MASK;
		if (hyd_run == HYD_UP)
			f[FN_HYD_UP] = 1'b1;
		else if (hyd_run == HYD_DOWN)
			f[FN_HYD_DOWN] = 1'b1;
		f[FN_TRAM_RIGHT] = tram_st[0];
		f[FN_TRAM_LEFT]  = tram_st[1];
		f[FN_GEO_STOP]   = geo_st;
		return f;
	endfunction

	// Unassigned outputs and the valve pair hold their last level.
	function automatic void drive_relays();
		logic [4:0] fn;
		for (int n = 0; n < NUM_OUTPUTS && n < LEVEL_W; n++) begin
			fn = fmap_reg[5*n +: 5];
			if (!(valve_reg && n >= 4) && fn != 5'd0 && fn <= FUNC_COUNT)
				levels_st[n] = active_hi_reg ^ flags_st[fn - 5'd1];
		end
	endfunction

	function automatic void clear_machine();
		flags_st   = '0;
		sect_st    = '0;
		hyd_run    = HYD_OFF;
		hyd_timing = 1'b0;
		hyd_ms     = '0;
		tram_st    = '0;
		geo_st     = 1'b0;
		drive_relays();
		wd_armed   = 1'b0;
		wd_count   = '0;
	endfunction

	function automatic void predict_relays(item_t it);
		result_t               r;
		logic [FUNC_COUNT-1:0] prior;
		int unsigned           hold_ms;
		r = '0;
		case (it.opcode)
		OP_TICK: begin
			if (link_prev && !it.link_up) begin
				clear_machine();
				r.outputs_written = 1'b1;
				link_clears++;
			end
			link_prev = it.link_up;
			if (wd_armed) begin
				if (wd_count != WD_MAX)
					wd_count = wd_count + 1'b1;
				if (wd_count > WATCHDOG_MS) begin
					clear_machine();
					r.outputs_written  = 1'b1;
					r.watchdog_tripped = 1'b1;
					wd_clears++;
				end
			end
			if (hyd_timing && hyd_ms != ELAPSED_MAX)
				hyd_ms = hyd_ms + 1'b1;
			if (hyd_en_reg && hyd_run != HYD_OFF && hyd_timing) begin
				hold_ms = (hyd_run == HYD_UP) ? raise_s_reg : lower_s_reg;
				hold_ms = hold_ms * MS_PER_S;
				if (hyd_ms > hold_ms) begin
					hyd_run    = HYD_OFF;
					hyd_timing = 1'b0;
					hyd_ms     = '0;
					flags_st   = machine_flags();
					drive_relays();
					r.outputs_written = 1'b1;
					hyd_stops++;
				end
			end
		end
		OP_MESSAGE: if (it.length_ok) begin
			prior    = flags_st;
			wd_armed = 1'b1;
			wd_count = '0;
			if (hyd_en_reg && it.hyd_command != hyd_last) begin
				hyd_run    = it.hyd_command;
				hyd_timing = (it.hyd_command != HYD_OFF);
				hyd_ms     = '0;
				hyd_last   = it.hyd_command;
			end
			tram_st  = it.tram_byte[1:0];
			geo_st   = |it.geo_byte;
			sect_st  = sect_on_reg ? (it.section_bits & SECTION_MASK) : '0;
			flags_st = machine_flags();
			if (flags_st != prior) begin
				drive_relays();
				r.outputs_written = 1'b1;
			end
		end
		OP_REFRESH: begin
			drive_relays();
			r.outputs_written = 1'b1;
		end
		default: ;
		endcase
		r.pin_levels     = levels_st;
		r.function_flags = flags_st;
		r.hyd_active     = hyd_run;
		relay_results_q.push_back(r);
	endfunction

	function automatic void queue_item(opcode_t op, logic link, logic len_ok,
			logic [7:0] hyd, logic [7:0] tram, logic [7:0] geo, logic [15:0] secs);
		item_t it;
		it.opcode       = op;
		it.link_up      = link;
		it.length_ok    = len_ok;
		it.hyd_command  = hyd;
		it.tram_byte    = tram;
		it.geo_byte     = geo;
		it.section_bits = secs;
		machine_items_q.push_back(it);
	endfunction

	// Ticks ignore everything but link_up; fill the rest with noise.
	function automatic void queue_ticks(int count);
		for (int k = 0; k < count; k++)
			queue_item(OP_TICK, 1'b1, 1'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 16'($urandom));
	endfunction

	function automatic void queue_message(logic [7:0] hyd);
		logic [7:0]  geo;
		logic [15:0] secs;
		geo = $urandom_range(1) ? 8'h00 : 8'($urandom);
		case ($urandom_range(5))
		0: secs = 16'h0000;
		1: secs = 16'hFFFF;
		default: secs = 16'($urandom);
		endcase
		queue_item(OP_MESSAGE, 1'($urandom), 1'b1, hyd, 8'($urandom), geo, secs);
	endfunction

	function automatic logic [MAP_W-1:0] random_map();
		logic [MAP_W-1:0] m;
		for (int n = 0; n < 6; n++)
			m[5*n +: 5] = ($urandom_range(5) == 0) ? 5'($urandom_range(31))
				: 5'($urandom_range(1, FUNC_COUNT));
		return m;
	endfunction

	function automatic void queue_random_event();
		int unsigned pick;
		int unsigned hold_ms;
		logic [7:0]  hyd;
		pick = $urandom_range(99);
		if (pick < 44) begin
			case ($urandom_range(5))
			0: hyd = HYD_OFF;
			1: hyd = HYD_DOWN;
			2, 3: hyd = HYD_UP;
			default: hyd = 8'($urandom);
			endcase
			queue_message(hyd);
		end else if (pick < 78)
			queue_item(OP_TICK, ($urandom_range(9) != 0), 1'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), 16'($urandom));
		else if (pick < 86)
			queue_item(OP_REFRESH, 1'($urandom), 1'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), 16'($urandom));
		else if (pick < 92)
			queue_item(OP_MESSAGE, 1'($urandom), 1'b0, 8'($urandom), 8'($urandom),
				8'($urandom), 16'($urandom));
		else if (pick < 95 || bursts_left == 0)
			queue_item(OP_NONE, 1'($urandom), 1'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), 16'($urandom));
		else begin
			bursts_left--;
			hyd = $urandom_range(1) ? HYD_UP : 8'($urandom_range(1, 255));
			hold_ms = (hyd == HYD_UP) ? raise_s_reg : lower_s_reg;
			hold_ms = hold_ms * MS_PER_S;
			if (hyd_en_reg && hold_ms == 0 && $urandom_range(1)) begin
				// force a command change, then tick around the zero-length one-shot expiry
				queue_message(HYD_OFF);
				queue_message(hyd);
				queue_ticks($urandom_range(2));
			end else begin
				// a short run of ticks after a message
				queue_message(hyd);
				queue_ticks(1 + $urandom_range(3));
			end
		end
	endfunction

	// Upper data bits are junk for the narrow registers; the block masks them.
	task automatic load_config(logic [7:0] raise_s, logic [7:0] lower_s, logic hyd_en,
			logic act_hi, logic [MAP_W-1:0] fmap, logic valve, logic sect_on);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_RAISE_SECONDS;
		cfg_data  <= {22'($urandom), raise_s};
		@(posedge clk);
		cfg_index <= CFG_LOWER_SECONDS;
		cfg_data  <= {22'($urandom), lower_s};
		@(posedge clk);
		cfg_index <= CFG_HYD_ENABLE;
		cfg_data  <= {29'($urandom), hyd_en};
		@(posedge clk);
		cfg_index <= CFG_PIN_ACTIVE_HI;
		cfg_data  <= {29'($urandom), act_hi};
		@(posedge clk);
		cfg_index <= CFG_OUTPUT_MAP;
		cfg_data  <= fmap;
		@(posedge clk);
		cfg_index <= CFG_VALVE_MODE;
		cfg_data  <= {29'($urandom), valve};
		@(posedge clk);
		cfg_index <= CFG_SECTION_ACTIVE;
		cfg_data  <= {29'($urandom), sect_on};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		raise_s_reg   = raise_s;
		lower_s_reg   = lower_s;
		hyd_en_reg    = hyd_en;
		active_hi_reg = act_hi;
		fmap_reg      = fmap;
		valve_reg     = valve;
		sect_on_reg   = sect_on;
		@(negedge clk);
	endtask

	// Hold off until the block has returned every expected result.
	task automatic wait_idle();
		while (machine_items_q.size() != 0 || in_valid || relay_results_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_relays(drv_item);
				items_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (machine_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_item <= machine_items_q.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (relay_results_q.size() == 0) begin
					$error("unexpected result transaction: pin_levels %h function_flags %h",
						pin_levels, function_flags);
					fail_count++;
				end else begin
					want = relay_results_q.pop_front();
					results_seen++;
					if (pin_levels !== want.pin_levels) begin
						$error("pin_levels: expected %h, got %h", want.pin_levels, pin_levels);
						fail_count++;
					end
					if (outputs_written !== want.outputs_written) begin
						$error("outputs_written: expected %b, got %b",
							want.outputs_written, outputs_written);
						fail_count++;
					end
					if (function_flags !== want.function_flags) begin
						$error("function_flags: expected %h, got %h",
							want.function_flags, function_flags);
						fail_count++;
					end
					if (hyd_active !== want.hyd_active) begin
						$error("hyd_active: expected %h, got %h", want.hyd_active, hyd_active);
						fail_count++;
					end
					if (watchdog_tripped !== want.watchdog_tripped) begin
						$error("watchdog_tripped: expected %b, got %b",
							want.watchdog_tripped, watchdog_tripped);
						fail_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset register values: hydraulics off, active high, outputs mapped 1..6
		queue_item(OP_REFRESH, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000);
		queue_item(OP_NONE, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		queue_item(OP_MESSAGE, 1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		queue_item(OP_MESSAGE, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		queue_item(OP_MESSAGE, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		queue_item(OP_MESSAGE, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 16'h0000);
		queue_item(OP_MESSAGE, 1'b1, 1'b1, HYD_UP, 8'h02, 8'h80, 16'h0001);
		queue_item(OP_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000);
		queue_item(OP_TICK, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		queue_item(OP_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000);
		queue_item(OP_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000);
		queue_item(OP_REFRESH, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = (p == 0) ? 0 : 15;
			recv_idle_pct = send_idle_pct;
			bursts_left   = 2;
			case (p)
			0: load_config(8'd1, 8'd0, 1'b1, 1'b1,
				{5'd1, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17}, 1'b0, 1'b1);
			1: load_config(8'd0, 8'd1, 1'b1, 1'b0, random_map(), 1'b1, 1'b1);
			2: load_config(8'd255, 8'd255, 1'b1, 1'b1, '1, 1'b0, 1'b0);
			3: load_config(8'd0, 8'd0, 1'b0, 1'b0, '0, 1'b1, 1'b1);
			default: load_config(
				($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1)),
				($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1)),
				1'b1, 1'($urandom), random_map(), 1'($urandom), ($urandom_range(4) != 0));
			endcase

			if (p == 0) begin
				// one-shot handling: same command ignored, lower timer for non-raise codes
				queue_item(OP_MESSAGE, 1'b1, 1'b1, HYD_UP, 8'h01, 8'h00, 16'h8000);
				queue_item(OP_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000);
				queue_item(OP_MESSAGE, 1'b1, 1'b1, HYD_UP, 8'h01, 8'h00, 16'h8000);
				queue_item(OP_MESSAGE, 1'b1, 1'b1, HYD_DOWN, 8'h00, 8'h01, 16'h8000);
				queue_item(OP_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000);
				queue_item(OP_MESSAGE, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h00, 16'h0000);
				queue_item(OP_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000);
				queue_item(OP_MESSAGE, 1'b1, 1'b1, HYD_OFF, 8'h00, 8'h00, 16'h0000);
			end

			for (int k = 0; k < EVENTS_PER_PHASE; k++) begin
				queue_random_event();
				if (k == EVENTS_PER_PHASE / 2)
					wait_idle();
			end
			wait_idle();
		end

		repeat (10) @(negedge clk);
		$display("Summary: %0d transactions in, %0d results checked over %0d register settings",
			items_accepted, results_seen, PHASES + 1);
		$display("Summary: %0d link-fall clears, %0d watchdog clears, %0d hydraulic expiries",
			link_clears, wd_clears, hyd_stops);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout: results still outstanding: %0d", relay_results_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
